FILE: rtl/core/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Shared types and sizes for the path length accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pla_pkg;

  // Coordinate and fixed-point format
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;

  // Derived datapath sizes
  localparam int SQ_W      = 2 * COORD_WIDTH;          // one squared delta
  localparam int SUMSQ_W   = SQ_W + 1;                 // dx^2 + dy^2
  localparam int RAD_RAW_W = SUMSQ_W + 2 * FRAC_BITS;  // radicand with fraction
  localparam int RAD_W     = RAD_RAW_W + (RAD_RAW_W % 2);
  localparam int ROOT_W    = RAD_W / 2;                // one root bit per step
  localparam int REM_W     = ROOT_W + 1;
  localparam int CNT_W     = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  // Fixed result field widths
  localparam int STEP_W  = 25;
  localparam int TOTAL_W = 32;

  // Stream payload widths (byte padded)
  localparam int IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STEP_W + TOTAL_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADD,
    ST_ROOT,
    ST_ACCUM,
    ST_WRITE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture a new point request
    logic diff;       // form absolute deltas
    logic mul_x;      // square dx
    logic mul_y;      // square dy
    logic add;        // sum squares, seed the root unit
    logic root_step;  // one root bit
    logic accum;      // saturating add into the total
    logic write;      // fill the output register, retire the point
  } pla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic measure;    // a step from a previous point is due
  } pla_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/pla_ctrl.sv
// ----------------------------------------------------------------------------
// pla_ctrl
// Sequencer for the path length accumulator: handshakes and step order.
// ----------------------------------------------------------------------------
`default_nettype none

module pla_ctrl
  import pla_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        m_tready,
  output logic             m_tvalid,
  input  wire pla_status_t status,
  output pla_cmd_t         cmd
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.write) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = status.measure ? ST_MUL_X : ST_WRITE;
      end
      ST_MUL_X: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_y  = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        cnt_next   = CNT_W'(ROOT_W - 1);
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_ACCUM;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/pla_datapath.sv
// ----------------------------------------------------------------------------
// pla_datapath
// Point registers, shared squarer, bit-serial square root and total.
// ----------------------------------------------------------------------------
`default_nettype none

module pla_datapath
  import pla_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pla_cmd_t               cmd,
  output pla_status_t                 status,
  input  wire logic [COORD_WIDTH-1:0] in_x,
  input  wire logic [COORD_WIDTH-1:0] in_y,
  input  wire logic                   in_start,
  input  wire logic                   in_end,
  output logic                        out_valid_flag,
  output logic [STEP_W-1:0]           out_step,
  output logic [TOTAL_W-1:0]          out_total,
  output logic                        out_last
);

  // control state
  logic                   have_previous;
  logic                   cur_start;
  logic                   cur_end;
  // payload
  logic [COORD_WIDTH-1:0] cur_x;
  logic [COORD_WIDTH-1:0] cur_y;
  logic [COORD_WIDTH-1:0] previous_x;
  logic [COORD_WIDTH-1:0] previous_y;
  logic [COORD_WIDTH-1:0] dx;
  logic [COORD_WIDTH-1:0] dy;
  logic [SQ_W-1:0]        prod;
  logic [SQ_W-1:0]        sq_x;
  logic [RAD_W-1:0]       rad;
  logic [REM_W-1:0]       rem;
  logic [ROOT_W-1:0]      root;
  logic [TOTAL_W-1:0]     running_total;

  logic signed [COORD_WIDTH:0] diff_x;
  logic signed [COORD_WIDTH:0] diff_y;
  logic [COORD_WIDTH:0]        abs_x;
  logic [COORD_WIDTH:0]        abs_y;
  logic [SUMSQ_W-1:0]          sumsq;
  logic [REM_W+1:0]            rem_trial;
  logic [REM_W+1:0]            root_trial;
  logic                        bit_fits;
  logic [TOTAL_W:0]            total_sum;

  assign status.measure = have_previous && !cur_start;

  assign diff_x = $signed({cur_x[COORD_WIDTH-1], cur_x})
                - $signed({previous_x[COORD_WIDTH-1], previous_x});
  assign diff_y = $signed({cur_y[COORD_WIDTH-1], cur_y})
                - $signed({previous_y[COORD_WIDTH-1], previous_y});
  assign abs_x  = diff_x[COORD_WIDTH] ? (COORD_WIDTH+1)'(-diff_x) : diff_x;
  assign abs_y  = diff_y[COORD_WIDTH] ? (COORD_WIDTH+1)'(-diff_y) : diff_y;

  assign sumsq = {1'b0, sq_x} + {1'b0, prod};

  // restoring square root: bring down two radicand bits, try root*4+1
  assign rem_trial  = {rem, rad[RAD_W-1 -: 2]};
  assign root_trial = (REM_W+2)'({root, 2'b01});
  assign bit_fits   = rem_trial >= root_trial;

  assign total_sum = {1'b0, running_total} + (TOTAL_W+1)'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      cur_start     <= 1'b0;
      cur_end       <= 1'b0;
      running_total <= '0;
      previous_x    <= '0;
      previous_y    <= '0;
    end else begin
      if (cmd.load) begin
        cur_start <= in_start;
        cur_end   <= in_end;
      end
      if (cmd.accum) begin
        running_total <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
      if (cmd.write) begin
        previous_x    <= cur_x;
        previous_y    <= cur_y;
        have_previous <= !cur_end;
        if (!status.measure) begin
          running_total <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= in_x;
      cur_y <= in_y;
    end
    if (cmd.diff) begin
      dx <= abs_x[COORD_WIDTH-1:0];
      dy <= abs_y[COORD_WIDTH-1:0];
    end
    if (cmd.mul_x) begin
      prod <= dx * dx;
    end
    if (cmd.mul_y) begin
      sq_x <= prod;
      prod <= dy * dy;
    end
    if (cmd.add) begin
      rad  <= RAD_W'({sumsq, {(2 * FRAC_BITS){1'b0}}});
      rem  <= '0;
      root <= '0;
    end
    if (cmd.root_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= bit_fits ? REM_W'(rem_trial - root_trial) : REM_W'(rem_trial);
      root <= {root[ROOT_W-2:0], bit_fits};
    end
    if (cmd.write) begin
      out_valid_flag <= status.measure;
      out_step       <= status.measure ? STEP_W'(root) : '0;
      out_total      <= status.measure ? running_total : '0;
      out_last       <= cur_end;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/path_length_accumulator_top.sv
// ----------------------------------------------------------------------------
// path_length_accumulator_top
// Euclidean path length accumulator over a stream of integer points.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one path point per request: tdata holds x and y
//   (two's complement), tuser flags the first point of a path, tlast the
//   last one. Master stream returns one result per point: tdata holds the
//   step length and the running total (both with 8 fractional bits),
//   tuser flags that a step was measured, tlast echoes the path end.
//   A measured point passes capture, delta, squaring of dx and dy, sum,
//   the root steps, accumulate and write; a first point of a path goes
//   from capture and delta straight to write. The bit-serial square root,
//   one root bit per cycle, sets the rate; a new point is taken only after
//   the current one has been written.
//   The result sits in an output register; a new point is taken while it
//   waits. If the receiver stalls, the next result holds in the datapath
//   and no further point is taken until the output register frees up.
//   Reset (rst, synchronous) clears the previous point and the total and
//   empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module path_length_accumulator_top
  import pla_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // slave side: point requests
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y
  input  wire logic                  s_tuser,   // path_start
  input  wire logic                  s_tlast,   // path_end
  // master side: results
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // step_distance, total_distance, pad
  output logic                       m_tuser,   // step_valid
  output logic                       m_tlast    // last
);

  pla_cmd_t            cmd;
  pla_status_t         status;
  logic [STEP_W-1:0]   step_distance;
  logic [TOTAL_W-1:0]  total_distance;

  // sequencer: owns both handshakes
  pla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and held path state
  pla_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_x           (s_tdata[COORD_WIDTH-1:0]),
    .in_y           (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_start       (s_tuser),
    .in_end         (s_tlast),
    .out_valid_flag (m_tuser),
    .out_step       (step_distance),
    .out_total      (total_distance),
    .out_last       (m_tlast)
  );

  // pack the result, step in the low bits, zero pad to whole bytes
  assign m_tdata = OUT_DATA_W'({total_distance, step_distance});

endmodule

`default_nettype wire
